/* rtl/adc_sample_calibrator_core_macros.svh */
// assertion macros shared by the calibrator rtl files
`ifndef ADC_SAMPLE_CALIBRATOR_CORE_MACROS_SVH
`define ADC_SAMPLE_CALIBRATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define ASC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition that must never be seen out of reset
`define ASC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASC_ASSERT(lbl, prop, msg)
`define ASC_NEVER(lbl, cond, msg)
`endif
`endif

/* rtl/asc_pkg.sv */
// shared types, codes and widths of the adc sample calibrator
package asc_pkg;

	// converter and conversion constants
	localparam int ADC_BITS = 12;
	localparam int FULL_SCALE_MV = 2400;
	localparam int MV_W = $clog2(FULL_SCALE_MV + 1);
	localparam int RAW_W = ADC_BITS;
	localparam int VAL_W = 32;
	localparam int FRAC_BITS = 16;

	// datapath widths
	localparam int SPAN_W = RAW_W + 1;
	localparam int OPA_W = (MV_W + 1 > SPAN_W) ? MV_W + 1 : SPAN_W;
	localparam int OPB_W = VAL_W + 1;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int SUM_W = PROD_W + 1;

	// configuration port and queue
	localparam int CFG_IDX_W = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_RAW_LOW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_RAW_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_REF_LOW = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_REF_HIGH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS = 3'd6;

	// mode codes
	localparam logic [1:0] MODE_MV = 2'd0;
	localparam logic [1:0] MODE_LINEAR = 2'd1;
	localparam logic [1:0] MODE_TWO_POINT = 2'd2;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_CAL_EQUAL = 2'd1,
		STATUS_READ_FAILED = 2'd2
	} status_t;

	// operation picked by the front end
	typedef enum logic [1:0] {
		OP_ZERO = 2'd0,
		OP_MV = 2'd1,
		OP_LINEAR = 2'd2,
		OP_TWO_POINT = 2'd3
	} op_t;

	typedef struct packed {
		logic [RAW_W-1:0] sample;
		logic read_failed;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] physical_value;
		status_t status;
	} out_item_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [RAW_W-1:0] cal_raw_low;
		logic [RAW_W-1:0] cal_raw_high;
		logic signed [VAL_W-1:0] cal_ref_low;
		logic signed [VAL_W-1:0] cal_ref_high;
		logic signed [VAL_W-1:0] gain;
		logic signed [VAL_W-1:0] bias;
	} cfg_t;

	// classified item between front and back
	typedef struct packed {
		op_t op;
		status_t status;
		logic [RAW_W-1:0] sample;
		logic [MV_W-1:0] mv;
	} q_item_t;

	// one divider stage
	typedef struct packed {
		status_t status;
		logic divide;
		logic neg;
		logic signed [VAL_W-1:0] addend;
		logic [RAW_W-1:0] divisor;
		logic [RAW_W-1:0] rem;
		logic [PROD_W-1:0] dq;
	} div_t;

endpackage

/* rtl/asc_front.sv */
// front end: configuration registers, input stage and classification
module asc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [asc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [asc_pkg::VAL_W-1:0] cfg_data,
	input  logic sample_valid,
	output logic sample_stall,
	input  asc_pkg::in_item_t sample_data,
	output asc_pkg::cfg_t cfg,
	output logic push,
	output asc_pkg::q_item_t push_data,
	input  logic full
);
	import asc_pkg::*;

	cfg_t cfg_q;
	logic vld_s1;
	q_item_t item_s1;
	q_item_t item_c;
	logic take;
	logic [RAW_W+MV_W-1:0] mv_prod;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_MV;
			cfg_q.cal_raw_low <= '0;
			cfg_q.cal_raw_high <= '1;
			cfg_q.cal_ref_low <= '0;
			cfg_q.cal_ref_high <= '0;
			cfg_q.gain <= VAL_W'(32'sd65536);
			cfg_q.bias <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE: cfg_q.mode <= cfg_data[1:0];
				REG_CAL_RAW_LOW: cfg_q.cal_raw_low <= cfg_data[RAW_W-1:0];
				REG_CAL_RAW_HIGH: cfg_q.cal_raw_high <= cfg_data[RAW_W-1:0];
				REG_CAL_REF_LOW: cfg_q.cal_ref_low <= $signed(cfg_data);
				REG_CAL_REF_HIGH: cfg_q.cal_ref_high <= $signed(cfg_data);
				REG_GAIN: cfg_q.gain <= $signed(cfg_data);
				REG_BIAS: cfg_q.bias <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// millivolts, truncated
	assign mv_prod = {{MV_W{1'b0}}, sample_data.sample} * (RAW_W+MV_W)'(FULL_SCALE_MV);

	// classify the sample
	always_comb begin
		item_c.sample = sample_data.sample;
		item_c.mv = mv_prod[RAW_W+MV_W-1:RAW_W];
		priority if (sample_data.read_failed) begin
			item_c.op = OP_ZERO;
			item_c.status = STATUS_READ_FAILED;
		end else if (cfg_q.mode == MODE_TWO_POINT) begin
			if (cfg_q.cal_raw_low == cfg_q.cal_raw_high) begin
				item_c.op = OP_ZERO;
				item_c.status = STATUS_CAL_EQUAL;
			end else begin
				item_c.op = OP_TWO_POINT;
				item_c.status = STATUS_OK;
			end
		end else if (cfg_q.mode == MODE_LINEAR) begin
			item_c.op = OP_LINEAR;
			item_c.status = STATUS_OK;
		end else begin
			item_c.op = OP_MV;
			item_c.status = STATUS_OK;
		end
	end

	// input stage handshake
	assign push = vld_s1 && !full;
	assign sample_stall = vld_s1 && full;
	assign take = sample_valid && !sample_stall;
	assign push_data = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_c;
		end
	end

endmodule

/* rtl/asc_queue.sv */
// short queue between front end and back end
`include "adc_sample_calibrator_core_macros.svh"
module asc_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  asc_pkg::q_item_t push_data,
	output logic full,
	input  logic pop,
	output asc_pkg::q_item_t pop_data,
	output logic empty
);
	import asc_pkg::*;

	q_item_t entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;

	assign full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign pop_data = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`ASC_NEVER(a_q_overflow, push && full && !pop, "queue written while full")
	`ASC_NEVER(a_q_underflow, pop && empty, "queue read while empty")
	`ASC_ASSERT(a_q_count, (push && !pop) |=> (count_q != '0), "fill count lost a transfer")

endmodule

/* rtl/asc_back.sv */
// back end: multiply, restoring divider pipeline, offset add (bias or low reference) and saturation
`include "adc_sample_calibrator_core_macros.svh"
module asc_back (
	input  logic clk,
	input  logic arst_n,
	input  asc_pkg::cfg_t cfg,
	output logic pop,
	input  asc_pkg::q_item_t pop_data,
	input  logic empty,
	output logic result_valid,
	input  logic result_stall,
	output asc_pkg::out_item_t result_data
);
	import asc_pkg::*;

	localparam int NSTG = PROD_W;
	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32'sh7fffffff);
	localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(32'sh80000000);

	logic adv;

	// multiply stage
	logic signed [SPAN_W-1:0] diff_raw;
	logic signed [OPB_W-1:0] diff_ref;
	logic signed [SPAN_W-1:0] span_c;
	logic signed [OPA_W-1:0] opa;
	logic signed [OPB_W-1:0] opb;
	logic signed [PROD_W-1:0] mul_c;
	logic signed [VAL_W-1:0] addend_c;

	logic vld_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [SPAN_W-1:0] span_s1;
	logic signed [VAL_W-1:0] addend_s1;
	op_t op_s1;
	status_t status_s1;

	// divider chain, entry zero is the magnitude stage
	logic [NSTG:0] stage_vld_q;
	div_t stage_q [NSTG+1];
	div_t head_c;
	logic [SPAN_W-1:0] abs_span;

	// output stage
	div_t last;
	logic signed [SUM_W-1:0] base;
	logic signed [SUM_W-1:0] sum;
	logic signed [VAL_W-1:0] value_c;
	logic result_valid_q;
	out_item_t result_q;

	// one bit of restoring division
	function automatic div_t div_step(div_t a);
		div_t r;
		logic [RAW_W:0] trial;
		r = a;
		trial = {a.rem, a.dq[PROD_W-1]};
		if (trial >= {1'b0, a.divisor}) begin
			r.rem = RAW_W'(trial - {1'b0, a.divisor});
			r.dq = {a.dq[PROD_W-2:0], 1'b1};
		end else begin
			r.rem = trial[RAW_W-1:0];
			r.dq = {a.dq[PROD_W-2:0], 1'b0};
		end
		return r;
	endfunction

	assign adv = !result_valid_q || !result_stall;
	assign pop = adv && !empty;

	// operand selection for the shared multiplier
	always_comb begin
		diff_raw = $signed({1'b0, pop_data.sample}) - $signed({1'b0, cfg.cal_raw_low});
		diff_ref = OPB_W'(cfg.cal_ref_high) - OPB_W'(cfg.cal_ref_low);
		span_c = $signed({1'b0, cfg.cal_raw_high}) - $signed({1'b0, cfg.cal_raw_low});
		if (pop_data.op == OP_TWO_POINT) begin
			opa = OPA_W'(diff_raw);
			opb = diff_ref;
		end else begin
			opa = OPA_W'($signed({1'b0, pop_data.mv}));
			opb = OPB_W'(cfg.gain);
		end
		unique case (pop_data.op)
			OP_ZERO: begin
				mul_c = '0;
				addend_c = '0;
			end
			OP_MV: begin
				mul_c = PROD_W'({pop_data.mv, {FRAC_BITS{1'b0}}});
				addend_c = '0;
			end
			OP_LINEAR: begin
				mul_c = opa * opb;
				addend_c = cfg.bias;
			end
			OP_TWO_POINT: begin
				mul_c = opa * opb;
				addend_c = cfg.cal_ref_low;
			end
			default: begin
				mul_c = '0;
				addend_c = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= mul_c;
			span_s1 <= span_c;
			addend_s1 <= addend_c;
			op_s1 <= pop_data.op;
			status_s1 <= pop_data.status;
		end
	end

	// magnitudes and quotient sign
	always_comb begin
		abs_span = span_s1[SPAN_W-1] ? (~span_s1 + 1'b1) : span_s1;
		head_c.status = status_s1;
		head_c.divide = (op_s1 == OP_TWO_POINT);
		head_c.addend = addend_s1;
		head_c.divisor = abs_span[RAW_W-1:0];
		head_c.rem = '0;
		if (op_s1 == OP_TWO_POINT) begin
			head_c.neg = prod_s1[PROD_W-1] ^ span_s1[SPAN_W-1];
			head_c.dq = prod_s1[PROD_W-1] ? (~prod_s1 + 1'b1) : prod_s1;
		end else begin
			head_c.neg = 1'b0;
			head_c.dq = prod_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q[0] <= 1'b0;
		end else if (adv) begin
			stage_vld_q[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stage_q[0] <= head_c;
		end
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= NSTG; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				stage_vld_q[k] <= 1'b0;
			end else if (adv) begin
				stage_vld_q[k] <= stage_vld_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stage_q[k] <= stage_q[k-1].divide ? div_step(stage_q[k-1]) : stage_q[k-1];
			end
		end
	end

	// sign, offset and saturation
	always_comb begin
		last = stage_q[NSTG];
		if (last.divide) begin
			base = last.neg ? -$signed({1'b0, last.dq}) : $signed({1'b0, last.dq});
		end else begin
			base = SUM_W'($signed(last.dq));
		end
		sum = base + SUM_W'(last.addend);
		priority if (last.status != STATUS_OK) begin
			value_c = '0;
		end else if (sum > SAT_MAX) begin
			value_c = 32'sh7fffffff;
		end else if (sum < SAT_MIN) begin
			value_c = 32'sh80000000;
		end else begin
			value_c = sum[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= stage_vld_q[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q.physical_value <= value_c;
			result_q.status <= last.status;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data = result_q;

	`ASC_ASSERT(a_err_zero, (result_valid && result_data.status != STATUS_OK) |-> (result_data.physical_value == '0), "error result carries a value")
	`ASC_ASSERT(a_cal_equal_mode, (result_valid && result_data.status == STATUS_CAL_EQUAL) |-> (cfg.mode == MODE_TWO_POINT), "equal-points status outside two-point mode")
	`ASC_ASSERT(a_hold_blocked, (result_valid && result_stall) |=> $stable(stage_vld_q), "pipeline moved while output blocked")

endmodule

/* rtl/adc_sample_calibrator_core.sv */
// top level of the adc sample calibrator
//
//   channel   signals                                   transfer when
//   sample    sample_valid sample_stall sample_data     valid high, stall low
//   result    result_valid result_stall result_data     valid high, stall low
//   config    cfg_we cfg_index cfg_data                 cfg_we high
//
// one sample per cycle sustained while the result side does not stall; the result passes through:
// input stage, queue, multiply, magnitude, 46 divider stages, output
// the divider is a restoring pipeline with one quotient bit per stage over the 46-bit product
// reset clears valid bits, queue pointers and configuration; no clearing pass is needed
// a stalled result freezes the back end; the queue then fills and stalls the sample side
module adc_sample_calibrator_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [asc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [asc_pkg::VAL_W-1:0] cfg_data,
	input  logic sample_valid,
	output logic sample_stall,
	input  asc_pkg::in_item_t sample_data,
	output logic result_valid,
	input  logic result_stall,
	output asc_pkg::out_item_t result_data
);
	import asc_pkg::*;

	cfg_t cfg;
	logic push;
	q_item_t push_data;
	logic full;
	logic pop;
	q_item_t pop_data;
	logic empty;

	// classification and configuration
	asc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_data(sample_data),
		.cfg(cfg),
		.push(push),
		.push_data(push_data),
		.full(full)
	);

	// decoupling queue
	asc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.pop(pop),
		.pop_data(pop_data),
		.empty(empty)
	);

	// arithmetic
	asc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.pop(pop),
		.pop_data(pop_data),
		.empty(empty),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data)
	);

endmodule

/* bench/tb_adc_sample_calibrator_core.sv */
// self-checking testbench for the adc sample calibrator core
`timescale 1ns / 100ps

module tb_adc_sample_calibrator_core;
	import asc_pkg::*;

	localparam int DRAIN_CYCLES = 64;
	localparam int HOLD_CYCLES = 300;
	localparam int STUCK_LIMIT = 4000;
	localparam int REPORT_LIMIT = 10;
	localparam longint VAL_MAX = 64'sd2147483647;
	localparam longint VAL_MIN = -64'sd2147483648;
	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_style_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [VAL_W-1:0] cfg_data;
	logic sample_valid;
	logic sample_stall;
	in_item_t sample_data;
	logic result_valid;
	logic result_stall;
	out_item_t result_data;

	// calibration registers as the block should hold them
	cfg_t cal_regs;
	out_item_t pending_results[$];
	int fail_count;
	int stuck_cycles;
	int burst_left;
	bit allow_gaps;
	int holds_requested;
	int holds_served;
	stall_style_t stall_style;
	int style_left;
	int stall_tick;

	adc_sample_calibrator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample_data(sample_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// expected value and status of one sample under the current registers
	function automatic out_item_t calibrate_sample(input in_item_t item);
		longint raw;
		longint mv;
		longint span;
		longint ref_lo;
		longint ref_hi;
		longint acc;
		out_item_t r;
		raw = longint'(item.sample);
		mv = (raw * FULL_SCALE_MV) >>> ADC_BITS;
		ref_lo = longint'($signed(cal_regs.cal_ref_low));
		ref_hi = longint'($signed(cal_regs.cal_ref_high));
		span = longint'(cal_regs.cal_raw_high) - longint'(cal_regs.cal_raw_low);
		r.physical_value = '0;
		r.status = STATUS_OK;
		// a failed read wins over everything else
		if (item.read_failed) begin
			r.status = STATUS_READ_FAILED;
			return r;
		end
		case (cal_regs.mode)
			MODE_TWO_POINT: begin
				if (span == 0) begin
					r.status = STATUS_CAL_EQUAL;
					return r;
				end
				acc = (raw - longint'(cal_regs.cal_raw_low)) * (ref_hi - ref_lo) / span + ref_lo;
			end
			MODE_LINEAR: begin
				acc = mv * longint'($signed(cal_regs.gain)) + longint'($signed(cal_regs.bias));
			end
			default: begin
				acc = mv <<< FRAC_BITS;
			end
		endcase
		if (acc > VAL_MAX) begin
			acc = VAL_MAX;
		end else if (acc < VAL_MIN) begin
			acc = VAL_MIN;
		end
		r.physical_value = acc[31:0];
		return r;
	endfunction

	// q16.16 value biased toward extremes and small magnitudes
	function automatic logic [31:0] pick_q16();
		int v;
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3, 4: begin
				v = $urandom_range(0, 2097152);
				return v - 1048576;
			end
			default: return $urandom();
		endcase
	endfunction

	function automatic cfg_t pick_config();
		cfg_t c;
		int pick;
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			c.mode = MODE_MV;
		end else if (pick == 1) begin
			c.mode = MODE_UNUSED;
		end else if (pick < 5) begin
			c.mode = MODE_LINEAR;
		end else begin
			c.mode = MODE_TWO_POINT;
		end
		case ($urandom_range(0, 5))
			0: begin
				c.cal_raw_low = 12'($urandom_range(0, 4095));
				c.cal_raw_high = c.cal_raw_low;
			end
			1: begin
				c.cal_raw_low = 12'd0;
				c.cal_raw_high = 12'd4095;
			end
			2: begin
				c.cal_raw_low = 12'd4095;
				c.cal_raw_high = 12'd0;
			end
			default: begin
				c.cal_raw_low = 12'($urandom_range(0, 4095));
				c.cal_raw_high = 12'($urandom_range(0, 4095));
			end
		endcase
		c.cal_ref_low = pick_q16();
		c.cal_ref_high = pick_q16();
		c.gain = ($urandom_range(0, 4) == 0) ? 32'h0001_0000 : pick_q16();
		c.bias = pick_q16();
		return c;
	endfunction

	// raw sample, often at the ends or next to a calibration point
	function automatic logic [11:0] pick_sample();
		int v;
		case ($urandom_range(0, 9))
			0: return 12'd0;
			1: return 12'd4095;
			2, 3: begin
				v = $urandom_range(0, 1) ? int'(cal_regs.cal_raw_low) : int'(cal_regs.cal_raw_high);
				v = v + $urandom_range(0, 6) - 3;
				if (v < 0) begin
					v = 0;
				end else if (v > 4095) begin
					v = 4095;
				end
				return v[11:0];
			end
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	// one sample transfer, with a random gap between bursts
	task automatic offer_sample(input logic [11:0] raw, input logic failed);
		int gap;
		in_item_t item;
		item.sample = raw;
		item.read_failed = failed;
		if (burst_left == 0) begin
			gap = allow_gaps ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				@(negedge clk);
				sample_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		burst_left--;
		@(negedge clk);
		sample_valid = 1'b1;
		sample_data = item;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		pending_results.push_back(calibrate_sample(item));
	endtask

	// let every outstanding result come back before touching registers
	task automatic wait_drained();
		@(negedge clk);
		sample_valid = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic program_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_MODE: cal_regs.mode = data[1:0];
			REG_CAL_RAW_LOW: cal_regs.cal_raw_low = data[11:0];
			REG_CAL_RAW_HIGH: cal_regs.cal_raw_high = data[11:0];
			REG_CAL_REF_LOW: cal_regs.cal_ref_low = data;
			REG_CAL_REF_HIGH: cal_regs.cal_ref_high = data;
			REG_GAIN: cal_regs.gain = data;
			REG_BIAS: cal_regs.bias = data;
			default: ;
		endcase
	endtask

	// full register set, junk above the narrow fields
	task automatic apply_config(input cfg_t c);
		wait_drained();
		program_register(REG_MODE, ($urandom() & 32'hffff_fffc) | c.mode);
		program_register(REG_CAL_RAW_LOW, ($urandom() & 32'hffff_f000) | c.cal_raw_low);
		program_register(REG_CAL_RAW_HIGH, ($urandom() & 32'hffff_f000) | c.cal_raw_high);
		program_register(REG_CAL_REF_LOW, c.cal_ref_low);
		program_register(REG_CAL_REF_HIGH, c.cal_ref_high);
		program_register(REG_GAIN, c.gain);
		program_register(REG_BIAS, c.bias);
	endtask

	task automatic run_random_segment(input int count);
		cfg_t c;
		c = pick_config();
		apply_config(c);
		repeat (count) offer_sample(pick_sample(), $urandom_range(0, 9) == 0);
	endtask

	// register values straight out of reset
	task automatic test_reset_values();
		offer_sample(12'd0, 1'b0);
		offer_sample(12'd4095, 1'b0);
		offer_sample(12'd2048, 1'b0);
		offer_sample(12'd1, 1'b0);
	endtask

	// millivolt mode and the unused mode code that falls back to it
	task automatic test_millivolt_modes();
		wait_drained();
		program_register(REG_MODE, 32'(MODE_MV));
		offer_sample(12'haaa, 1'b0);
		offer_sample(12'h555, 1'b0);
		wait_drained();
		program_register(REG_MODE, 32'(MODE_UNUSED));
		offer_sample(12'd4095, 1'b0);
		offer_sample(12'd1234, 1'b0);
	endtask

	// gain and bias at the ends of their range, saturating both ways
	task automatic test_linear_extremes();
		wait_drained();
		program_register(REG_MODE, 32'(MODE_LINEAR));
		program_register(REG_GAIN, 32'h7fff_ffff);
		program_register(REG_BIAS, 32'h7fff_ffff);
		offer_sample(12'd4095, 1'b0);
		wait_drained();
		program_register(REG_GAIN, 32'h8000_0000);
		program_register(REG_BIAS, 32'h8000_0000);
		offer_sample(12'd4095, 1'b0);
		wait_drained();
		program_register(REG_GAIN, 32'hffff_0000);
		program_register(REG_BIAS, 32'h0001_8000);
		offer_sample(12'd1706, 1'b0);
	endtask

	// equal points, reversed points and saturation in two-point mode
	task automatic test_two_point_cases();
		wait_drained();
		program_register(REG_MODE, 32'(MODE_TWO_POINT));
		program_register(REG_CAL_RAW_LOW, 32'd100);
		program_register(REG_CAL_RAW_HIGH, 32'd100);
		offer_sample(12'd100, 1'b0);
		wait_drained();
		program_register(REG_CAL_RAW_LOW, 32'd4095);
		program_register(REG_CAL_RAW_HIGH, 32'd0);
		program_register(REG_CAL_REF_LOW, 32'h8000_0000);
		program_register(REG_CAL_REF_HIGH, 32'h7fff_ffff);
		offer_sample(12'd0, 1'b0);
		offer_sample(12'd2048, 1'b0);
		offer_sample(12'd4095, 1'b0);
		wait_drained();
		program_register(REG_CAL_RAW_LOW, 32'd0);
		program_register(REG_CAL_RAW_HIGH, 32'd1);
		program_register(REG_CAL_REF_LOW, 32'd0);
		offer_sample(12'd4095, 1'b0);
		wait_drained();
		program_register(REG_CAL_REF_HIGH, 32'h8000_0000);
		offer_sample(12'd4095, 1'b0);
	endtask

	// a failed read beats equal points and any mode
	task automatic test_read_failure_priority();
		wait_drained();
		program_register(REG_CAL_RAW_LOW, 32'd2048);
		program_register(REG_CAL_RAW_HIGH, 32'd2048);
		offer_sample(12'd2048, 1'b1);
		offer_sample(12'd4095, 1'b1);
		wait_drained();
		program_register(REG_MODE, 32'(MODE_LINEAR));
		offer_sample(12'd3000, 1'b1);
	endtask

	// a write past the last register changes nothing
	task automatic test_unused_register_index();
		wait_drained();
		program_register(REG_MODE, 32'(MODE_TWO_POINT));
		program_register(REG_NONE, 32'hffff_ffff);
		offer_sample(12'd2048, 1'b0);
	endtask

	// long result stall while samples keep coming, so the input side backs up
	task automatic test_output_backpressure();
		cfg_t c;
		c = pick_config();
		apply_config(c);
		allow_gaps = 1'b0;
		holds_requested++;
		repeat (120) offer_sample(pick_sample(), $urandom_range(0, 9) == 0);
		allow_gaps = 1'b1;
	endtask

	task automatic test_random_traffic();
		for (int k = 0; k < 9; k++) begin
			allow_gaps = (k % 3) != 2;
			run_random_segment(148);
		end
		allow_gaps = 1'b1;
	endtask

	// result side stall pattern, with a long hold on request
	initial begin
		result_stall = 1'b0;
		style_left = 0;
		stall_tick = 0;
		forever begin
			@(negedge clk);
			if (holds_served < holds_requested) begin
				result_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_served++;
				result_stall = 1'b0;
			end else begin
				if (style_left == 0) begin
					stall_style = stall_style_t'($urandom_range(0, 3));
					style_left = $urandom_range(16, 200);
				end
				style_left--;
				stall_tick++;
				case (stall_style)
					STALL_NONE: result_stall = 1'b0;
					STALL_LIGHT: result_stall = $urandom_range(0, 3) == 0;
					STALL_HEAVY: result_stall = $urandom_range(0, 3) != 0;
					default: result_stall = (stall_tick % 5) < 2;
				endcase
			end
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				if (fail_count < REPORT_LIMIT) begin
					$display("unexpected result: value %0d status %0d",
						result_data.physical_value, result_data.status);
				end
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_data.physical_value !== want.physical_value ||
						result_data.status !== want.status) begin
					if (fail_count < REPORT_LIMIT) begin
						$display("mismatch: expected value %0d status %0d, got value %0d status %0d",
							want.physical_value, want.status,
							result_data.physical_value, result_data.status);
					end
					fail_count++;
				end
			end
		end
	end

	// cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n) begin
			stuck_cycles <= 0;
		end else if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || cfg_we) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	initial begin
		wait (stuck_cycles >= STUCK_LIMIT);
		$display("tb_adc_sample_calibrator_core: done, errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_valid = 1'b0;
		sample_data = '0;
		fail_count = 0;
		burst_left = 0;
		allow_gaps = 1'b1;
		holds_requested = 0;
		holds_served = 0;
		cal_regs.mode = MODE_MV;
		cal_regs.cal_raw_low = 12'd0;
		cal_regs.cal_raw_high = 12'd4095;
		cal_regs.cal_ref_low = 32'd0;
		cal_regs.cal_ref_high = 32'd0;
		cal_regs.gain = 32'h0001_0000;
		cal_regs.bias = 32'd0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_millivolt_modes();
		test_linear_extremes();
		test_two_point_cases();
		test_read_failure_priority();
		test_unused_register_index();
		test_output_backpressure();
		test_random_traffic();
		wait_drained();

		if (fail_count == 0) begin
			$display("tb_adc_sample_calibrator_core: done, clean");
		end else begin
			$display("tb_adc_sample_calibrator_core: done, errors");
		end
		$finish;
	end

endmodule
